>>> rtl/core/tms_pkg.sv
// Shared types and constants for the three-way merge sorter.
// No dependencies; imported by every module of the block.
package tms_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned DataW    = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] value_res;
    logic                    last_res;
  } out_word_t;

endpackage

>>> rtl/core/tms_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on tms_pkg for the data width.
module tms_ram import tms_pkg::*; #(
  parameter int unsigned Depth = MaxItems
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [DataW-1:0]           wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [DataW-1:0]           rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/three_way_merge_sorter.sv
// Top level of the three-way merge sorter: load, merge sequencer and emission.
// Depends on tms_pkg and instantiates two tms_ram banks.
//
//  Channel | Direction | Handshake                | Word
//  --------+-----------+--------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o  | in_word_i  (value, last)
//  out     | output    | out_valid_o / out_ready_i| out_word_o (value_res, last_res)
//
// Loading takes one cycle per word. After a last word the set of n values is
// sorted by bottom-up three-way merge passes (run width 1, 3, 9, ...), ping-ponging
// between two RAM banks; each merged value takes a read of a run head, its capture
// and a write of the least head in turn, since the RAM has a single read port.
// Each value is emitted by a read, a capture and a wait for out_ready_i. Input is not taken
// while a set is sorted or emitted. Reset clears the count and the sequencer;
// the RAM banks need no clearing since only entries of the current set are read.
module three_way_merge_sorter import tms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = MaxItems
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  // run bounds reach below 4n, so two spare bits
  localparam int unsigned PtrW  = CntW + 2;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_GRP   = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_ERD   = 3'd3;
  localparam logic [2:0] S_EWT   = 3'd4;
  localparam logic [2:0] S_EOUT  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            side_q, side_d;      // bank holding the current source runs
  logic [PtrW-1:0] w_q, w_d;            // run width of this pass
  logic [PtrW-1:0] base_q, base_d;      // start of current group of three runs
  logic [PtrW-1:0] wp_q, wp_d;          // merge write pointer
  logic [PtrW-1:0] ptr_q [3];
  logic [PtrW-1:0] ptr_d [3];
  logic [PtrW-1:0] end_q [3];
  logic [PtrW-1:0] end_d [3];
  logic [DataW-1:0] head_q [3];
  logic [DataW-1:0] head_d [3];
  logic [2:0]      hv_q, hv_d;
  logic            rdp_q, rdp_d;        // head read in flight
  logic [1:0]      rsel_q, rsel_d;
  logic            ov_q, ov_d;
  out_word_t       ow_q, ow_d;

  logic             we0, we1;
  logic [AddrW-1:0] waddr, raddr;
  logic [DataW-1:0] wdata, rd0, rd1, rdata;

  tms_ram #(.Depth(MAX_ITEMS)) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd0)
  );

  tms_ram #(.Depth(MAX_ITEMS)) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd1)
  );

  assign rdata = side_q ? rd1 : rd0;

  function automatic logic [PtrW-1:0] min_p(logic [PtrW-1:0] a, logic [PtrW-1:0] b);
    min_p = (a < b) ? a : b;
  endfunction

  always_comb begin
    logic [PtrW-1:0]  n_ext;
    logic [PtrW-1:0]  nb, nw;
    logic [2:0]       need;
    logic [1:0]       sel, pk;
    logic             found;
    logic [DataW-1:0] best;

    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    side_d  = side_q;
    w_d     = w_q;
    base_d  = base_q;
    wp_d    = wp_q;
    ptr_d   = ptr_q;
    end_d   = end_q;
    head_d  = head_q;
    hv_d    = hv_q;
    rdp_d   = rdp_q;
    rsel_d  = rsel_q;
    ov_d    = ov_q;
    ow_d    = ow_q;
    we0     = 1'b0;
    we1     = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = '0;
    in_ready_o = 1'b0;

    n_ext = PtrW'(cnt_q);
    nb    = base_q + w_q + w_q + w_q;
    nw    = w_q + w_q + w_q;
    for (int r = 0; r < 3; r++) begin
      need[r] = !hv_q[r] && (ptr_q[r] < end_q[r]);
    end
    sel = need[0] ? 2'd0 : (need[1] ? 2'd1 : 2'd2);
    // least head; on a tie the later run wins
    pk    = 2'd0;
    found = 1'b0;
    best  = head_q[0];
    for (int r = 0; r < 3; r++) begin
      if (hv_q[r] && (!found || !($signed(best) < $signed(head_q[r])))) begin
        pk    = 2'(r);
        best  = head_q[r];
        found = 1'b1;
      end
    end

    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // drop values beyond capacity, last still starts the sort
          if (cnt_q < CntW'(MAX_ITEMS)) begin
            we0   = 1'b1;
            waddr = cnt_q[AddrW-1:0];
            wdata = in_word_i.value;
            cnt_d = cnt_q + 1'b1;
          end
          if (in_word_i.last) begin
            side_d  = 1'b0;
            w_d     = PtrW'(1);
            base_d  = '0;
            idx_d   = '0;
            state_d = (cnt_d > CntW'(1)) ? S_GRP : S_ERD;
          end
        end
      end
      S_GRP: begin
        end_d[0] = min_p(base_q + w_q, n_ext);
        end_d[1] = min_p(base_q + w_q + w_q, n_ext);
        end_d[2] = min_p(nb, n_ext);
        ptr_d[0] = base_q;
        ptr_d[1] = end_d[0];
        ptr_d[2] = end_d[1];
        wp_d     = base_q;
        hv_d     = '0;
        rdp_d    = 1'b0;
        state_d  = S_MERGE;
      end
      S_MERGE: begin
        if (rdp_q) begin
          head_d[rsel_q] = rdata;
          hv_d[rsel_q]   = 1'b1;
          rdp_d          = 1'b0;
        end else if (|need) begin
          raddr       = ptr_q[sel][AddrW-1:0];
          ptr_d[sel]  = ptr_q[sel] + 1'b1;
          rdp_d       = 1'b1;
          rsel_d      = sel;
        end else if (|hv_q) begin
          we0       = side_q;
          we1       = !side_q;
          waddr     = wp_q[AddrW-1:0];
          wdata     = best;
          wp_d      = wp_q + 1'b1;
          hv_d[pk]  = 1'b0;
        end else if (nb >= n_ext) begin
          side_d  = !side_q;
          base_d  = '0;
          w_d     = nw;
          idx_d   = '0;
          state_d = (nw >= n_ext) ? S_ERD : S_GRP;
        end else begin
          base_d  = nb;
          state_d = S_GRP;
        end
      end
      S_ERD: begin
        raddr   = idx_q[AddrW-1:0];
        state_d = S_EWT;
      end
      S_EWT: begin
        ow_d.value_res = rdata;
        ow_d.last_res  = (idx_q + 1'b1) == cnt_q;
        ov_d           = 1'b1;
        state_d        = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (ow_q.last_res) begin
            cnt_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      side_q  <= 1'b0;
      w_q     <= '0;
      base_q  <= '0;
      wp_q    <= '0;
      hv_q    <= '0;
      rdp_q   <= 1'b0;
      rsel_q  <= '0;
      ov_q    <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        ptr_q[r] <= '0;
        end_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      side_q  <= side_d;
      w_q     <= w_d;
      base_q  <= base_d;
      wp_q    <= wp_d;
      hv_q    <= hv_d;
      rdp_q   <= rdp_d;
      rsel_q  <= rsel_d;
      ov_q    <= ov_d;
      ptr_q   <= ptr_d;
      end_q   <= end_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    ow_q   <= ow_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;

`ifndef SYNTHESIS
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_EOUT)
    else $error("result valid outside emission");
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result waits");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_ITEMS))
    else $error("item count beyond capacity");
  a_read_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE && rdp_q) |=> (state_q == S_MERGE && !rdp_q))
    else $error("head read not captured");
`endif

endmodule
